@@ rtl/alfm_pkg.sv @@
`timescale 1ns / 1ps

package alfm_pkg;

   localparam int NumLists     = 16;
   localparam int LinesPerList = 64;

   localparam int ListW  = (NumLists > 1) ? $clog2(NumLists) : 1;
   localparam int CountW = $clog2(LinesPerList + 1);
   localparam int AddrW  = $clog2(2 * NumLists * LinesPerList);
   localparam int Depth  = 2 * NumLists * LinesPerList;

   localparam int OpcodeW = 2;
   localparam int IndexW  = 4;

   typedef enum logic [OpcodeW-1:0] {
      OP_ADD_STD  = 2'd0,
      OP_ADD_EXT  = 2'd1,
      OP_EVAL_STD = 2'd2,
      OP_EVAL_EXT = 2'd3
   } opcode_type;

   localparam logic DEC_PERMIT = 1'b0;
   localparam logic DEC_DENY   = 1'b1;
   localparam logic STS_DONE   = 1'b0;
   localparam logic STS_FULL   = 1'b1;

   // one stored rule; standard rules use only src fields and permit
   typedef struct packed {
      logic        any_protocol;
      logic        permit;
      logic [7:0]  protocol;
      logic [31:0] dst_wild;
      logic [31:0] dst_ip;
      logic [31:0] src_wild;
      logic [31:0] src_ip;
   } rule_type;

   // packet key held during a walk
   typedef struct packed {
      logic        is_ext;
      logic [7:0]  protocol;
      logic [31:0] dst_ip;
      logic [31:0] src_ip;
   } key_type;

endpackage

@@ rtl/alfm_match.sv @@
`timescale 1ns / 1ps

// Rule compare for one stored entry against the packet key.
module alfm_match (
   input  alfm_pkg::rule_type rule,
   input  alfm_pkg::key_type  key,
   output logic               hit
);

   logic std_hit;
   logic proto_ok;
   logic src_ok;
   logic dst_ok;

   always_comb begin
      std_hit  = ((key.src_ip ^ rule.src_ip) & ~rule.src_wild) == 32'd0;
      // extended stored addresses compare unmasked
      proto_ok = rule.any_protocol || (rule.protocol == key.protocol);
      src_ok   = (key.src_ip & ~rule.src_wild) == rule.src_ip;
      dst_ok   = (key.dst_ip & ~rule.dst_wild) == rule.dst_ip;
      hit      = key.is_ext ? (proto_ok && src_ok && dst_ok) : std_hit;
   end

endmodule

@@ rtl/access_list_first_match_classifier.sv @@
`timescale 1ns / 1ps

// First-match IPv4 access-list classifier. Holds 16 standard and 16 extended
// lists of up to 64 ordered rules each in one single-port-read rule RAM
// (2048 x 138, registered read port). Every request transfer yields one
// response transfer. Add requests (opcode 0/1) append a rule and answer
// without a walk; a full list returns status 1. Evaluate requests
// (opcode 2/3) walk the addressed list one rule per cycle through the RAM
// read port, each rule first registered and then compared, and stop at
// the first hit or after the last rule. An empty list denies without a
// walk. Decision 0 is permit, 1 is deny; no hit denies. A new request is
// taken only while the block is idle and no response waits, or the waiting
// response transfers in that same cycle.
// Rule RAM contents are not cleared at reset; only the per-list counts are.
module access_list_first_match_classifier (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // src_ip[31:0], src_wild[63:32], dst_ip[95:64], dst_wild[127:96],
   // protocol[135:128], permit[136], any_protocol[137], zero pad
   input  logic [143:0] req_tdata,
   // opcode[1:0], list_index[5:2]
   input  logic [5:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // decision[0], status[1], zero pad
   output logic [7:0]   rsp_tdata
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // request unpack
   alfm_pkg::opcode_type          req_op;
   logic [alfm_pkg::IndexW-1:0]   req_list;
   alfm_pkg::rule_type            req_rule;
   logic                          list_ok;
   logic [alfm_pkg::ListW-1:0]    list_sel;
   logic                          req_ext;
   logic [alfm_pkg::CountW-1:0]   req_count;
   logic                          req_fire;
   logic                          is_add;
   logic                          list_full;
   logic                          do_write;

   assign req_op   = alfm_pkg::opcode_type'(req_tuser[1:0]);
   assign req_list = req_tuser[5:2];
   assign req_rule = alfm_pkg::rule_type'(req_tdata[137:0]);

   // per-list rule counts
   logic [alfm_pkg::CountW-1:0] std_cnt_ff [alfm_pkg::NumLists];
   logic [alfm_pkg::CountW-1:0] ext_cnt_ff [alfm_pkg::NumLists];

   // rule RAM and its read port
   alfm_pkg::rule_type          rule_mem [alfm_pkg::Depth];
   alfm_pkg::rule_type          rd_data_ff;
   logic [alfm_pkg::AddrW-1:0]  wr_addr;
   logic [alfm_pkg::AddrW-1:0]  rd_addr;
   logic                        rd_en;

   // walk control
   alfm_pkg::key_type           key_ff, key_in;
   logic [alfm_pkg::ListW-1:0]  list_ff, list_in;
   logic [alfm_pkg::CountW-1:0] num_ff, num_in;
   logic [alfm_pkg::CountW-1:0] issue_ff, issue_in;
   logic [alfm_pkg::CountW-1:0] cmp_line_ff, cmp_line_in;
   logic                        rd_vld_ff, rd_vld_in;
   logic                        hit;

   // response register
   logic rsp_vld_ff, rsp_vld_in;
   logic rsp_dec_ff, rsp_dec_in;
   logic rsp_sts_ff, rsp_sts_in;

   always_comb begin
      list_ok   = 32'(req_list) < alfm_pkg::NumLists;
      list_sel  = alfm_pkg::ListW'(req_list);
      req_ext   = (req_op == alfm_pkg::OP_ADD_EXT) || (req_op == alfm_pkg::OP_EVAL_EXT);
      is_add    = (req_op == alfm_pkg::OP_ADD_STD) || (req_op == alfm_pkg::OP_ADD_EXT);
      req_count = req_ext ? ext_cnt_ff[list_sel] : std_cnt_ff[list_sel];
      list_full = !list_ok || (32'(req_count) >= alfm_pkg::LinesPerList);
      req_fire  = req_tvalid && req_tready;
      do_write  = req_fire && is_add && !list_full;
      wr_addr   = alfm_pkg::AddrW'(
                     ((32'(req_ext) * alfm_pkg::NumLists + 32'(list_sel))
                      * alfm_pkg::LinesPerList) + 32'(req_count));
      rd_addr   = alfm_pkg::AddrW'(
                     ((32'(key_ff.is_ext) * alfm_pkg::NumLists + 32'(list_ff))
                      * alfm_pkg::LinesPerList) + 32'(issue_ff));
   end

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_vld_ff || rsp_tready);

   alfm_match u_match (
      .rule (rd_data_ff),
      .key  (key_ff),
      .hit  (hit)
   );

   always_comb begin
      state_in    = state_ff;
      key_in      = key_ff;
      list_in     = list_ff;
      num_in      = num_ff;
      issue_in    = issue_ff;
      cmp_line_in = cmp_line_ff;
      rd_vld_in   = 1'b0;
      rd_en       = 1'b0;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_dec_in  = rsp_dec_ff;
      rsp_sts_in  = rsp_sts_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (is_add) begin
                  rsp_vld_in = 1'b1;
                  rsp_dec_in = alfm_pkg::DEC_PERMIT;
                  rsp_sts_in = list_full ? alfm_pkg::STS_FULL : alfm_pkg::STS_DONE;
               end else if (!list_ok || req_count == '0) begin
                  // unknown or empty list denies at once
                  rsp_vld_in = 1'b1;
                  rsp_dec_in = alfm_pkg::DEC_DENY;
                  rsp_sts_in = alfm_pkg::STS_DONE;
               end else begin
                  key_in.is_ext   = req_ext;
                  key_in.protocol = req_rule.protocol;
                  key_in.dst_ip   = req_rule.dst_ip;
                  key_in.src_ip   = req_rule.src_ip;
                  list_in         = list_sel;
                  num_in          = req_count;
                  issue_in        = '0;
                  state_in        = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            // issue the next line while the previous one is compared
            if (issue_ff < num_ff) begin
               rd_en       = 1'b1;
               rd_vld_in   = 1'b1;
               cmp_line_in = issue_ff;
               issue_in    = issue_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (hit) begin
                  rsp_vld_in = 1'b1;
                  rsp_dec_in = rd_data_ff.permit ? alfm_pkg::DEC_PERMIT
                                                 : alfm_pkg::DEC_DENY;
                  rsp_sts_in = alfm_pkg::STS_DONE;
                  rd_vld_in  = 1'b0;
                  state_in   = ST_IDLE;
               end else if (cmp_line_ff == num_ff - 1'b1) begin
                  rsp_vld_in = 1'b1;
                  rsp_dec_in = alfm_pkg::DEC_DENY;
                  rsp_sts_in = alfm_pkg::STS_DONE;
                  rd_vld_in  = 1'b0;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // rule RAM: one write port (adds), one registered read port (walk)
   always_ff @(posedge clock) begin
      if (do_write) begin
         rule_mem[wr_addr] <= req_rule;
      end
      if (rd_en) begin
         rd_data_ff <= rule_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < alfm_pkg::NumLists; i++) begin
            std_cnt_ff[i] <= '0;
            ext_cnt_ff[i] <= '0;
         end
      end else if (do_write) begin
         if (req_ext) begin
            ext_cnt_ff[list_sel] <= req_count + 1'b1;
         end else begin
            std_cnt_ff[list_sel] <= req_count + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      list_ff     <= list_in;
      num_ff      <= num_in;
      issue_ff    <= issue_in;
      cmp_line_ff <= cmp_line_in;
      rsp_dec_ff  <= rsp_dec_in;
      rsp_sts_ff  <= rsp_sts_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'd0, rsp_sts_ff, rsp_dec_ff};

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

   localparam int ClockPeriod = 12;
   localparam int MaxGap      = 13;
   localparam int RandomItems = 1250;
   localparam int HoldOff     = 400;
   localparam int DrainCycles = 80;

   // one request as driven, plus an optional hand-typed answer
   typedef struct {
      alfm_pkg::opcode_type op;
      logic [3:0]  idx;
      logic [31:0] src;
      logic [31:0] smask;
      logic [31:0] dst;
      logic [31:0] dmask;
      logic [7:0]  proto;
      logic        permit;
      logic        anyp;
      bit          typed;
      logic        dec;
      logic        sts;
   } acl_req_type;

   // same bit order as rsp_tdata[1:0]
   typedef struct packed {
      logic sts;
      logic dec;
   } verdict_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // src_ip, src_wild, dst_ip, dst_wild, protocol, permit, any_protocol, pad
   logic [143:0] req_tdata = '0;
   // opcode, list_index
   logic [5:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // decision, status, pad
   logic [7:0]   rsp_tdata;

   // shadow copy of the rule lists
   alfm_pkg::rule_type std_rules [alfm_pkg::NumLists][alfm_pkg::LinesPerList];
   alfm_pkg::rule_type ext_rules [alfm_pkg::NumLists][alfm_pkg::LinesPerList];
   int       std_count [alfm_pkg::NumLists];
   int       ext_count [alfm_pkg::NumLists];

   verdict_type verdicts_due[$];
   int       mismatches = 0;
   int       rsp_seen   = 0;

   always #(ClockPeriod / 2) clock = ~clock;

   access_list_first_match_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Directed rows: empty lists, extremes of every field, wildcard edges,
   // unmasked extended rule addresses, first-match shadowing, and mask
   // fields that must not matter on an evaluate.
   acl_req_type plan [24] = '{
      '{alfm_pkg::OP_EVAL_STD, 4'd3,  32'h0,        32'h0,        32'h0,        32'h0,
        8'd0,   1'b0, 1'b0, 1'b1, alfm_pkg::DEC_DENY,   alfm_pkg::STS_DONE},
      '{alfm_pkg::OP_EVAL_EXT, 4'd3,  32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
        32'hFFFFFFFF,
        8'd255, 1'b1, 1'b1, 1'b1, alfm_pkg::DEC_DENY,   alfm_pkg::STS_DONE},
      '{alfm_pkg::OP_ADD_STD,  4'd0,  32'h0A000000, 32'h000000FF, 32'h0,        32'h0,
        8'd0,   1'b1, 1'b0, 1'b1, alfm_pkg::DEC_PERMIT, alfm_pkg::STS_DONE},
      '{alfm_pkg::OP_EVAL_STD, 4'd0,  32'h0A00004D, 32'hFFFFFFFF, 32'h5A5A5A5A,
        32'hA5A5A5A5,
        8'd9,   1'b0, 1'b1, 1'b1, alfm_pkg::DEC_PERMIT, alfm_pkg::STS_DONE},
      '{alfm_pkg::OP_EVAL_STD, 4'd0,  32'h0A00014D, 32'h0,        32'h0,        32'h0,
        8'd0,   1'b0, 1'b0, 1'b1, alfm_pkg::DEC_DENY,   alfm_pkg::STS_DONE},
      '{alfm_pkg::OP_ADD_STD,  4'd15, 32'hFFFFFFFF, 32'h00000000, 32'h12345678,
        32'hFFFFFFFF,
        8'd255, 1'b0, 1'b1, 1'b1, alfm_pkg::DEC_PERMIT, alfm_pkg::STS_DONE},
      '{alfm_pkg::OP_EVAL_STD, 4'd15, 32'hFFFFFFFF, 32'h0,        32'h0,        32'h0,
        8'd0,   1'b0, 1'b0, 1'b0, 1'b0,       1'b0},
      '{alfm_pkg::OP_EVAL_STD, 4'd15, 32'hFFFFFFFE, 32'h0,        32'h0,        32'h0,
        8'd0,   1'b0, 1'b0, 1'b0, 1'b0,       1'b0},
      '{alfm_pkg::OP_ADD_STD,  4'd15, 32'h00000000, 32'hFFFFFFFF, 32'h0,        32'h0,
        8'd0,   1'b1, 1'b0, 1'b1, alfm_pkg::DEC_PERMIT, alfm_pkg::STS_DONE},
      '{alfm_pkg::OP_EVAL_STD, 4'd15, 32'h00000000, 32'h0,        32'h0,        32'h0,
        8'd0,   1'b0, 1'b0, 1'b0, 1'b0,       1'b0},
      '{alfm_pkg::OP_ADD_EXT,  4'd0,  32'hC0A80100, 32'h000000FF, 32'h0A010000,
        32'h0000FFFF,
        8'd6,   1'b1, 1'b0, 1'b1, alfm_pkg::DEC_PERMIT, alfm_pkg::STS_DONE},
      '{alfm_pkg::OP_EVAL_EXT, 4'd0,  32'hC0A80107, 32'h13572468, 32'h0A0133AA,
        32'h0F0F0F0F,
        8'd6,   1'b0, 1'b0, 1'b0, 1'b0,       1'b0},
      '{alfm_pkg::OP_EVAL_EXT, 4'd0,  32'hC0A80107, 32'h0,        32'h0A0133AA, 32'h0,
        8'd17,  1'b0, 1'b0, 1'b0, 1'b0,       1'b0},
      '{alfm_pkg::OP_ADD_EXT,  4'd0,  32'hC0A80101, 32'h000000FF, 32'h0A010000,
        32'h0000FFFF,
        8'd17,  1'b0, 1'b1, 1'b1, alfm_pkg::DEC_PERMIT, alfm_pkg::STS_DONE},
      '{alfm_pkg::OP_EVAL_EXT, 4'd0,  32'hC0A80105, 32'h0,        32'h0A010001, 32'h0,
        8'd17,  1'b1, 1'b1, 1'b0, 1'b0,       1'b0},
      '{alfm_pkg::OP_ADD_EXT,  4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
        32'hFFFFFFFF,
        8'd255, 1'b1, 1'b1, 1'b1, alfm_pkg::DEC_PERMIT, alfm_pkg::STS_DONE},
      '{alfm_pkg::OP_ADD_EXT,  4'd15, 32'h00000000, 32'hFFFFFFFF, 32'h00000000,
        32'hFFFFFFFF,
        8'd0,   1'b0, 1'b1, 1'b1, alfm_pkg::DEC_PERMIT, alfm_pkg::STS_DONE},
      '{alfm_pkg::OP_ADD_EXT,  4'd15, 32'h00000000, 32'hFFFFFFFF, 32'h00000000,
        32'hFFFFFFFF,
        8'd0,   1'b1, 1'b1, 1'b1, alfm_pkg::DEC_PERMIT, alfm_pkg::STS_DONE},
      '{alfm_pkg::OP_EVAL_EXT, 4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
        32'hFFFFFFFF,
        8'd255, 1'b1, 1'b1, 1'b0, 1'b0,       1'b0},
      '{alfm_pkg::OP_EVAL_EXT, 4'd15, 32'h0,        32'h0,        32'h0,        32'h0,
        8'd0,   1'b0, 1'b0, 1'b0, 1'b0,       1'b0},
      '{alfm_pkg::OP_ADD_EXT,  4'd7,  32'h01020304, 32'h0,        32'h05060708, 32'h0,
        8'd132, 1'b1, 1'b0, 1'b1, alfm_pkg::DEC_PERMIT, alfm_pkg::STS_DONE},
      '{alfm_pkg::OP_EVAL_EXT, 4'd7,  32'h01020304, 32'h0,        32'h05060708, 32'h0,
        8'd132, 1'b0, 1'b0, 1'b0, 1'b0,       1'b0},
      '{alfm_pkg::OP_EVAL_EXT, 4'd7,  32'h01020304, 32'h0,        32'h05060708, 32'h0,
        8'd131, 1'b0, 1'b0, 1'b0, 1'b0,       1'b0},
      '{alfm_pkg::OP_EVAL_STD, 4'd7,  32'h01020304, 32'h0,        32'h0,        32'h0,
        8'd0,   1'b0, 1'b0, 1'b1, alfm_pkg::DEC_DENY,   alfm_pkg::STS_DONE}
   };

   // Verdict for one request; adds also update the shadow lists.
   function automatic verdict_type classify(acl_req_type r);
      verdict_type v;
      alfm_pkg::rule_type rl;
      logic [31:0] keep;
      bit proto_ok;
      int n;
      v.dec = alfm_pkg::DEC_PERMIT;
      v.sts = alfm_pkg::STS_DONE;
      case (r.op)
         alfm_pkg::OP_ADD_STD: begin
            n = std_count[r.idx];
            if (n >= alfm_pkg::LinesPerList) begin
               v.sts = alfm_pkg::STS_FULL;
            end else begin
               rl = '0;
               rl.src_ip   = r.src;
               rl.src_wild = r.smask;
               rl.permit   = r.permit;
               std_rules[r.idx][n] = rl;
               std_count[r.idx] = n + 1;
            end
         end
         alfm_pkg::OP_ADD_EXT: begin
            n = ext_count[r.idx];
            if (n >= alfm_pkg::LinesPerList) begin
               v.sts = alfm_pkg::STS_FULL;
            end else begin
               rl.src_ip       = r.src;
               rl.src_wild     = r.smask;
               rl.dst_ip       = r.dst;
               rl.dst_wild     = r.dmask;
               rl.protocol     = r.proto;
               rl.permit       = r.permit;
               rl.any_protocol = r.anyp;
               ext_rules[r.idx][n] = rl;
               ext_count[r.idx] = n + 1;
            end
         end
         alfm_pkg::OP_EVAL_STD: begin
            v.dec = alfm_pkg::DEC_DENY;
            for (int k = 0; k < std_count[r.idx]; k++) begin
               rl   = std_rules[r.idx][k];
               keep = ~rl.src_wild;
               if ((r.src & keep) == (rl.src_ip & keep)) begin
                  v.dec = rl.permit ? alfm_pkg::DEC_PERMIT : alfm_pkg::DEC_DENY;
                  break;
               end
            end
         end
         default: begin
            // extended rule addresses are compared as stored, unmasked
            v.dec = alfm_pkg::DEC_DENY;
            for (int k = 0; k < ext_count[r.idx]; k++) begin
               rl = ext_rules[r.idx][k];
               proto_ok = rl.any_protocol || (rl.protocol == r.proto);
               if (proto_ok && ((r.src & ~rl.src_wild) == rl.src_ip)
                   && ((r.dst & ~rl.dst_wild) == rl.dst_ip)) begin
                  v.dec = rl.permit ? alfm_pkg::DEC_PERMIT : alfm_pkg::DEC_DENY;
                  break;
               end
            end
         end
      endcase
      return v;
   endfunction

   // Wildcard masks: mostly contiguous low-order runs, some odd ones.
   function automatic logic [31:0] pick_wildcard();
      int sel;
      logic [63:0] run;
      sel = $urandom_range(0, 9);
      run = (64'd1 << $urandom_range(0, 32)) - 64'd1;
      if (sel == 0) return 32'h0;
      if (sel == 1) return 32'hFFFFFFFF;
      if (sel == 2) return $urandom();
      return run[31:0];
   endfunction

   function automatic logic [7:0] pick_proto();
      case ($urandom_range(0, 4))
         0: return 8'd1;
         1: return 8'd6;
         2: return 8'd17;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Random request. List 0 is hit hard so both of its lists overflow;
   // most evaluates are built to hit a stored rule.
   function automatic acl_req_type random_req();
      acl_req_type r;
      alfm_pkg::rule_type rl;
      int sel;
      int n;
      sel = $urandom_range(0, 99);
      if (sel < 22)      r.op = alfm_pkg::OP_ADD_STD;
      else if (sel < 45) r.op = alfm_pkg::OP_ADD_EXT;
      else if (sel < 72) r.op = alfm_pkg::OP_EVAL_STD;
      else               r.op = alfm_pkg::OP_EVAL_EXT;
      sel = $urandom_range(0, 99);
      if (sel < 40)      r.idx = 4'd0;
      else if (sel < 60) r.idx = 4'($urandom_range(1, 3));
      else               r.idx = 4'($urandom_range(0, 15));
      r.src    = $urandom();
      r.smask  = $urandom();
      r.dst    = $urandom();
      r.dmask  = $urandom();
      r.proto  = pick_proto();
      r.permit = 1'($urandom_range(0, 1));
      r.anyp   = ($urandom_range(0, 3) == 0);
      r.typed  = 1'b0;
      r.dec    = 1'b0;
      r.sts    = 1'b0;
      case (r.op)
         alfm_pkg::OP_ADD_STD, alfm_pkg::OP_ADD_EXT: begin
            r.smask = pick_wildcard();
            r.dmask = pick_wildcard();
            // well-formed rules keep the wildcard bits of the address clear
            if ($urandom_range(0, 9) < 8) begin
               r.src = r.src & ~r.smask;
               r.dst = r.dst & ~r.dmask;
            end
         end
         alfm_pkg::OP_EVAL_STD: begin
            n = std_count[r.idx];
            if (n > 0 && $urandom_range(0, 9) < 7) begin
               rl = std_rules[r.idx][$urandom_range(0, n - 1)];
               r.src = (rl.src_ip & ~rl.src_wild) | (r.src & rl.src_wild);
            end
         end
         default: begin
            n = ext_count[r.idx];
            if (n > 0 && $urandom_range(0, 9) < 7) begin
               rl = ext_rules[r.idx][$urandom_range(0, n - 1)];
               r.src = rl.src_ip | ($urandom() & rl.src_wild);
               r.dst = rl.dst_ip | ($urandom() & rl.dst_wild);
               r.proto = rl.protocol;
               if ($urandom_range(0, 6) == 0)
                  r.proto = r.proto ^ (8'd1 << $urandom_range(0, 7));
            end
         end
      endcase
      return r;
   endfunction

   // Sender: gap, offer, wait for the transfer, then log the expectation.
   // Only one nonblocking write to req_tvalid per edge: after a transfer it
   // is either held high for a back-to-back item or dropped for a gap.
   bit send_burst = 1'b0;

   task automatic send_req(acl_req_type r);
      int gap;
      verdict_type v;
      if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
      gap = send_burst ? 0 : $urandom_range(0, MaxGap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, r.anyp, r.permit, r.proto, r.dmask, r.dst, r.smask, r.src};
      req_tuser  <= {r.idx, r.op};
      do @(posedge clock); while (!req_tready);
      v = classify(r);
      if (r.typed) begin
         v.dec = r.dec;
         v.sts = r.sts;
      end
      verdicts_due.push_back(v);
   endtask

   // Receiver: random stalls, bursts with tready held high, and two long
   // hold-offs so the block backs up and drops req_tready.
   bit recv_burst = 1'b0;

   initial begin : response_side
      int stall;
      verdict_type want;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
         stall = recv_burst ? 0 : $urandom_range(0, MaxGap);
         if (rsp_seen == 300 || rsp_seen == 900) stall = HoldOff;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         rsp_seen++;
         if (verdicts_due.size() == 0) begin
            $display("%0t: response with nothing pending: expected none, actual %b",
                     $time, rsp_tdata);
            mismatches++;
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_tdata[0] !== want.dec) begin
               $display("%0t: decision mismatch: expected %b, actual %b",
                        $time, want.dec, rsp_tdata[0]);
               mismatches++;
            end
            if (rsp_tdata[1] !== want.sts) begin
               $display("%0t: status mismatch: expected %b, actual %b",
                        $time, want.sts, rsp_tdata[1]);
               mismatches++;
            end
         end
      end
   end

   // Main sequence: reset, directed rows, random traffic, drain, verdict.
   initial begin : request_side
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (plan[i]) send_req(plan[i]);
      repeat (RandomItems) send_req(random_req());
      req_tvalid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin : watchdog
      #(ClockPeriod * 800000);
      $display("tb: done, errors");
      $finish;
   end

endmodule
